/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands: synchronous reset disables every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (expr)) \
    else $error("assertion failed: lbl");

// Antecedent implies consequent at the same edge.
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

`endif

/* src/psched_pkg.sv */
// ----------------------------------------------------------------------------
// psched_pkg
// Sizes, status codes and table entry type for the priority scheduler.
// ----------------------------------------------------------------------------
package psched_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int COUNT_W   = $clog2(MAX_TASKS + 1);

  localparam int ID_W   = 8;
  localparam int TIME_W = 16;
  localparam int PRI_W  = 8;
  localparam int STAT_W = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [STAT_W-1:0] STAT_LOAD_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_LOAD_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RAN       = 2'd2;
  localparam logic [STAT_W-1:0] STAT_IDLE      = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [PRI_W-1:0]  priority_lvl;
    logic [TIME_W-1:0] remaining;
  } task_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

endpackage

/* src/preemptive_priority_scheduler.sv */
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Task table with a per-tick priority scan; one comparator walks the loaded slots.
// ----------------------------------------------------------------------------
// channel | handshake          | payload
// in      | in_valid/in_stall  | command task_id ready_time priority_req
//         |                    | burst_length
// out     | out_valid/out_stall| status running_id finished finish_time
//         |                    | all_done time_overflow
//
// Load request: accepted in idle, result registered from the response state.
// Tick request: scan, run and response states; the loaded slots of the table memory
// are read one slot per cycle through a single compare unit, then the winner is
// written back. One request in flight; in_stall is high until the sequencer
// returns to idle, including any cycles the result waits on out_stall.
// Reset clears slot count, time and overflow flag; the table needs no clear.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module preemptive_priority_scheduler
  import psched_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  input  logic [ID_W-1:0]   task_id,
  input  logic [TIME_W-1:0] ready_time,
  input  logic [PRI_W-1:0]  priority_req,
  input  logic [TIME_W-1:0] burst_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic [ID_W-1:0]   running_id,
  output logic              finished,
  output logic [TIME_W-1:0] finish_time,
  output logic              all_done,
  output logic              time_overflow
);

  state_t state;

  task_entry_t table_mem [MAX_TASKS];
  task_entry_t rd_data;
  logic [SLOT_W-1:0] rd_addr;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  task_entry_t       mem_wdata;

  logic [COUNT_W-1:0] loaded_count;
  logic [COUNT_W-1:0] active_count;
  logic [TIME_W-1:0]  now_tick;
  logic               sat_flag;

  logic [COUNT_W-1:0] scan_idx;
  logic               rd_valid;
  logic [SLOT_W-1:0]  rd_idx;

  logic              found;
  task_entry_t       best;
  logic [SLOT_W-1:0] best_idx;

  logic [STAT_W-1:0] res_status;
  logic [ID_W-1:0]   res_id;
  logic              res_fin;
  logic [TIME_W-1:0] res_time;

  logic in_accept;
  logic eligible;
  logic better;
  logic scan_issue;
  logic table_full;

  assign in_stall   = (state != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign table_full = (loaded_count >= COUNT_W'(MAX_TASKS));
  assign scan_issue = (state == ST_SCAN) && (scan_idx < loaded_count);
  assign rd_addr    = scan_idx[SLOT_W-1:0];

  assign eligible = (rd_data.remaining != '0) && (rd_data.arrival <= now_tick);
  assign better   = !found
                 || (rd_data.priority_lvl < best.priority_lvl)
                 || ((rd_data.priority_lvl == best.priority_lvl)
                     && (rd_data.arrival < best.arrival));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = loaded_count[SLOT_W-1:0];
    mem_wdata = '{id: task_id, arrival: ready_time, priority_lvl: priority_req,
                  remaining: burst_length};
    if (in_accept && (command == CMD_LOAD) && (burst_length != '0) && !table_full) begin
      mem_we = 1'b1;
    end else if ((state == ST_RUN) && found) begin
      mem_we              = 1'b1;
      mem_waddr           = best_idx;
      mem_wdata           = best;
      mem_wdata.remaining = best.remaining - TIME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      loaded_count <= '0;
      active_count <= '0;
      now_tick     <= '0;
      sat_flag     <= 1'b0;
      scan_idx     <= '0;
      rd_valid     <= 1'b0;
      found        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            res_id   <= '0;
            res_fin  <= 1'b0;
            res_time <= '0;
            if (command == CMD_TICK) begin
              scan_idx <= '0;
              found    <= 1'b0;
              state    <= ST_SCAN;
            end else begin
              if ((burst_length != '0) && table_full) begin
                res_status <= STAT_LOAD_FULL;
              end else begin
                res_status <= STAT_LOAD_OK;
              end
              if ((burst_length != '0) && !table_full) begin
                loaded_count <= loaded_count + COUNT_W'(1);
                active_count <= active_count + COUNT_W'(1);
              end
              state <= ST_RESP;
            end
          end
        end
        ST_SCAN: begin
          rd_valid <= scan_issue;
          rd_idx   <= scan_idx[SLOT_W-1:0];
          if (scan_issue) begin
            scan_idx <= scan_idx + COUNT_W'(1);
          end
          if (rd_valid && eligible && better) begin
            found    <= 1'b1;
            best     <= rd_data;
            best_idx <= rd_idx;
          end
          if (!scan_issue && !rd_valid) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (found) begin
            res_status <= STAT_RAN;
            res_id     <= best.id;
            res_fin    <= (best.remaining == TIME_W'(1));
            if (best.remaining == TIME_W'(1)) begin
              active_count <= active_count - COUNT_W'(1);
            end
          end else begin
            res_status <= STAT_IDLE;
          end
          if (now_tick == TIME_MAX) begin
            sat_flag <= 1'b1;
            res_time <= now_tick;
          end else begin
            now_tick <= now_tick + TIME_W'(1);
            res_time <= now_tick + TIME_W'(1);
          end
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            running_id    <= res_id;
            finished      <= res_fin;
            finish_time   <= res_time;
            all_done      <= (active_count == '0);
            time_overflow <= sat_flag;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, loaded_count <= COUNT_W'(MAX_TASKS))
  `ASSERT_ALWAYS(a_active_le_loaded, clk, rst, active_count <= loaded_count)
  `ASSERT_IMPLIES(a_sat_at_max, clk, rst, sat_flag, now_tick == TIME_MAX)
  `ASSERT_ALWAYS(a_state_onehot, clk, rst, $onehot(state))

endmodule
